@@ rtl/tdpt_pkg.sv @@
// Shared types and constants for the trial-division prime test.
package tdpt_pkg;

   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/trial_division_prime_test.sv @@
// Trial-division prime test: top level with shared restoring divider.
//
// Takes one unsigned candidate per item and returns one item whose bit 0 is
// set when the candidate is prime. Candidates below 2, and even values
// other than 2, are answered without dividing. An odd candidate x is
// divided by 3, 5, 7, ... on a single restoring divider that retires one
// quotient bit per cycle, and the search stops once the divisor exceeds
// the quotient or divides exactly. A prime near 2^32 needs about 32768
// divisors; small values and composites with a small factor finish much
// sooner. One item is worked at a time and req_tready is low meanwhile;
// the finished result sits in an output register, so the next item can be
// taken while it waits.
module trial_division_prime_test #(
   parameter int NUM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [NUM_WIDTH-1:0] candidate, rest zero fill
   input  logic [((NUM_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] prime_flag, [7:1] zero
   output logic [tdpt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import tdpt_pkg::*;

   localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

   state_type              state_ff, state_in;
   logic [NUM_WIDTH-1:0]   x_ff, x_in;
   logic [NUM_WIDTH-1:0]   d_ff, d_in;
   logic [NUM_WIDTH-1:0]   dvd_ff, dvd_in;   // dividend shifting out, quotient in
   logic [NUM_WIDTH-1:0]   rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   flag_ff, flag_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic                   rsp_flag_ff, rsp_flag_in;

   logic [NUM_WIDTH-1:0]   cand;
   logic                   accept;
   logic                   out_free;
   logic [NUM_WIDTH:0]     trial;
   logic                   trial_ge;
   logic [NUM_WIDTH:0]     trial_sub;
   logic                   cand_small;
   logic                   cand_two;
   logic                   cand_even;
   logic                   d_over_q;
   logic                   rem_zero;

   assign cand       = req_tdata[NUM_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign cand_small = (cand[NUM_WIDTH-1:1] == '0);
   assign cand_two   = (cand == NUM_WIDTH'(2));
   assign cand_even  = !cand[0];

   // one restoring step of the shared divider
   assign trial     = {rem_ff, dvd_ff[NUM_WIDTH-1]};
   assign trial_ge  = (trial >= {1'b0, d_ff});
   assign trial_sub = trial - {1'b0, d_ff};

   assign d_over_q  = (d_ff > dvd_ff);
   assign rem_zero  = (rem_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cand_small || cand_two || cand_even) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (d_over_q || rem_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      x_in          = x_ff;
      d_in          = d_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      flag_in       = flag_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in    = cand;
               d_in    = NUM_WIDTH'(3);
               dvd_in  = cand;
               rem_in  = '0;
               cnt_in  = CNT_WIDTH'(NUM_WIDTH - 1);
               flag_in = cand_two;
            end
         end
         ST_DIVIDE: begin
            rem_in = trial_ge ? trial_sub[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
            dvd_in = {dvd_ff[NUM_WIDTH-2:0], trial_ge};
            cnt_in = cnt_ff - CNT_WIDTH'(1);
         end
         ST_CHECK: begin
            // divisor past the square root: prime; exact division: composite
            flag_in = d_over_q;
            if (!d_over_q && !rem_zero) begin
               d_in   = d_ff + NUM_WIDTH'(2);
               dvd_in = x_ff;
               rem_in = '0;
               cnt_in = CNT_WIDTH'(NUM_WIDTH - 1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_flag_in   = flag_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      d_ff        <= d_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      flag_ff     <= flag_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 1){1'b0}}, rsp_flag_ff};

endmodule

@@ rtl/tdpt_checker.sv @@
// Port-level checks for the trial-division prime test, bound to the top level.
module tdpt_checker #(
   parameter int NUM_WIDTH = 32
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((NUM_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tdpt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import tdpt_pkg::*;

   // no result may be pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after accepting an item");

   // only bit 0 of a result carries data
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_WIDTH-1:1] == '0))
      else $error("result pad bits not zero");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind trial_division_prime_test tdpt_checker #(.NUM_WIDTH(NUM_WIDTH)) u_tdpt_checker (.*);
